### rtl/eg_pkg.sv
package eg_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GENERATOR   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PUBLIC_KEY  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIVATE_KEY = 2'd3;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   localparam logic [1:0] ALU_MUL = 2'd0;
   localparam logic [1:0] ALU_RED = 2'd1;
   localparam logic [1:0] ALU_DIV = 2'd2;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

endpackage

### rtl/eg_alu.sv
// Shared bit-serial unit: ALU_MUL gives a*b mod m, ALU_RED gives a mod m,
// ALU_DIV gives q = a / b and r = a % b (b nonzero). One bit per cycle.
module eg_alu #(
   parameter int WORD_BITS = eg_pkg::WORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  eg_pkg::alu_cmd_type    cmd,
   input  logic [WORD_BITS-1:0]   op_a,
   input  logic [WORD_BITS-1:0]   op_b,
   input  logic [WORD_BITS-1:0]   op_m,
   output eg_pkg::alu_stat_type   stat,
   output logic [WORD_BITS-1:0]   res_q,
   output logic [WORD_BITS-1:0]   res_r
);
   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [1:0]           op_ff, op_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] a_ff, a_in, b_ff, b_in, m_ff, m_in, acc_ff, acc_in;
   logic [WORD_BITS:0]   dbl, sum, trial;
   logic                 top;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      top     = a_ff[WORD_BITS-1];
      dbl     = {acc_ff, 1'b0};
      sum     = '0;
      trial   = '0;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = CNT_BITS'(WORD_BITS);
         a_in    = op_a;
         b_in    = op_b;
         m_in    = (cmd.op == eg_pkg::ALU_DIV) ? op_b : op_m;
         acc_in  = '0;
      end else if (busy_ff) begin
         unique case (op_ff)
            eg_pkg::ALU_MUL: begin
               // MSB-first: acc = 2*acc mod m, then add a if bit of b
               dbl = {acc_ff, 1'b0};
               if (dbl >= {1'b0, m_ff}) dbl = dbl - {1'b0, m_ff};
               sum = dbl + (b_ff[WORD_BITS-1] ? {1'b0, a_ff} : '0);
               if (sum >= {1'b0, m_ff}) sum = sum - {1'b0, m_ff};
               acc_in = sum[WORD_BITS-1:0];
               b_in   = {b_ff[WORD_BITS-2:0], 1'b0};
            end
            default: begin
               // restoring division: remainder in acc, quotient shifts into a
               trial = {acc_ff, top};
               a_in  = {a_ff[WORD_BITS-2:0], 1'b0};
               if (trial >= {1'b0, m_ff}) begin
                  trial   = trial - {1'b0, m_ff};
                  a_in[0] = 1'b1;
               end
               acc_in = trial[WORD_BITS-1:0];
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   // mul operand a must be reduced; callers reduce it first
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign res_q     = a_ff;
   assign res_r     = acc_ff;

   a_alu_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("alu done without busy");
   a_alu_rem_below_m: assert property (@(posedge clock) disable iff (reset)
      (done_ff && m_ff != '0) |-> (acc_ff < m_ff))
      else $error("alu remainder not reduced");
   a_alu_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start)
      else $error("alu restarted while busy");
endmodule

### rtl/eg_seq.sv
module eg_seq #(
   parameter int WORD_BITS = eg_pkg::WORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   func,
   input  logic [WORD_BITS-1:0]   message,
   input  logic [WORD_BITS-1:0]   nonce,
   input  logic [WORD_BITS-1:0]   cipher_first,
   input  logic [WORD_BITS-1:0]   cipher_second,
   input  logic [WORD_BITS-1:0]   modulus,
   input  logic [WORD_BITS-1:0]   generator,
   input  logic [WORD_BITS-1:0]   public_key,
   input  logic [WORD_BITS-1:0]   private_key,
   output logic                   idle,
   output logic                   finish,
   output logic [WORD_BITS-1:0]   res_first,
   output logic [WORD_BITS-1:0]   res_second
);
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_RB     = 5'd1;   // reduce base
   localparam logic [4:0] S_RB_W   = 5'd2;
   localparam logic [4:0] S_EBIT   = 5'd3;
   localparam logic [4:0] S_MACC_W = 5'd4;
   localparam logic [4:0] S_SQ     = 5'd5;
   localparam logic [4:0] S_SQ_W   = 5'd6;
   localparam logic [4:0] S_PDONE  = 5'd7;
   localparam logic [4:0] S_RM     = 5'd8;   // reduce multiplicand
   localparam logic [4:0] S_RM_W   = 5'd9;
   localparam logic [4:0] S_FMUL_W = 5'd10;
   localparam logic [4:0] S_IV     = 5'd11;  // euclid step
   localparam logic [4:0] S_DIV_W  = 5'd12;
   localparam logic [4:0] S_QR_W   = 5'd13;  // q mod m
   localparam logic [4:0] S_QS_W   = 5'd14;  // q*s1 mod m
   localparam logic [4:0] S_OUT    = 5'd15;

   logic [4:0]           st_ff, st_in;
   logic                 func_ff, func_in, pass_ff, pass_in;
   logic [WORD_BITS-1:0] base_ff, base_in, exp_ff, exp_in, acc_ff, acc_in;
   logic [WORD_BITS-1:0] x_ff, x_in, first_ff, first_in, second_ff, second_in;
   logic [WORD_BITS-1:0] r0_ff, r0_in, r1_ff, r1_in, s0_ff, s0_in, s1_ff, s1_in;
   logic [WORD_BITS-1:0] q_ff, q_in, k_ff, k_in;

   eg_pkg::alu_cmd_type  cmd;
   eg_pkg::alu_stat_type stat;
   logic [WORD_BITS-1:0] op_a, op_b, res_q, res_r, one_m, sub_v;

   eg_alu #(.WORD_BITS(WORD_BITS)) u_alu (
      .clock(clock), .reset(reset), .cmd(cmd), .op_a(op_a), .op_b(op_b),
      .op_m(modulus), .stat(stat), .res_q(res_q), .res_r(res_r)
   );

   assign one_m = (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

   always_comb begin
      st_in     = st_ff;
      func_in   = func_ff;
      pass_in   = pass_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      first_in  = first_ff;
      second_in = second_ff;
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      s0_in     = s0_ff;
      s1_in     = s1_ff;
      q_in      = q_ff;
      k_in      = k_ff;
      cmd.start = 1'b0;
      cmd.op    = eg_pkg::ALU_RED;
      op_a      = '0;
      op_b      = '0;
      sub_v     = '0;
      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               func_in   = func;
               pass_in   = 1'b0;
               first_in  = '0;
               second_in = '0;
               k_in      = nonce;
               if (func == eg_pkg::FUNC_ENCRYPT) begin
                  base_in = generator;
                  exp_in  = nonce;
                  x_in    = message;
               end else begin
                  base_in = cipher_first;
                  exp_in  = private_key;
                  x_in    = cipher_second;
               end
               st_in = (modulus == '0) ? S_OUT : S_RB;
            end
         end
         S_RB: begin
            cmd.start = 1'b1;
            cmd.op    = eg_pkg::ALU_RED;
            op_a      = base_ff;
            acc_in    = one_m;
            st_in     = S_RB_W;
         end
         S_RB_W: if (stat.done) begin
            base_in = res_r;
            st_in   = S_EBIT;
         end
         S_EBIT: begin
            if (exp_ff == '0) st_in = S_PDONE;
            else if (exp_ff[0]) begin
               cmd.start = 1'b1;
               cmd.op    = eg_pkg::ALU_MUL;
               op_a      = acc_ff;
               op_b      = base_ff;
               st_in     = S_MACC_W;
            end else st_in = S_SQ;
         end
         S_MACC_W: if (stat.done) begin
            acc_in = res_r;
            st_in  = S_SQ;
         end
         S_SQ: begin
            cmd.start = 1'b1;
            cmd.op    = eg_pkg::ALU_MUL;
            op_a      = base_ff;
            op_b      = base_ff;
            st_in     = S_SQ_W;
         end
         S_SQ_W: if (stat.done) begin
            base_in = res_r;
            exp_in  = exp_ff >> 1;
            st_in   = S_EBIT;
         end
         S_PDONE: begin
            if (func_ff == eg_pkg::FUNC_ENCRYPT && !pass_ff) begin
               first_in = acc_ff;
               pass_in  = 1'b1;
               base_in  = public_key;
               exp_in   = k_ff;
               st_in    = S_RB;
            end else if (func_ff == eg_pkg::FUNC_ENCRYPT) begin
               st_in = S_RM;
            end else begin
               // start euclid on s = acc (already reduced)
               r0_in = acc_ff;
               r1_in = modulus;
               s0_in = one_m;
               s1_in = '0;
               st_in = S_IV;
            end
         end
         S_IV: begin
            if (r1_ff == '0) begin
               acc_in = s0_ff;
               st_in  = S_RM;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = eg_pkg::ALU_DIV;
               op_a      = r0_ff;
               op_b      = r1_ff;
               st_in     = S_DIV_W;
            end
         end
         S_DIV_W: if (stat.done) begin
            q_in      = res_q;
            r0_in     = r1_ff;
            r1_in     = res_r;
            cmd.start = 1'b0;
            st_in     = S_QR_W;
         end
         S_QR_W: begin
            if (!stat.busy && !stat.done && q_ff != '1 ) begin
               cmd.start = 1'b1;
               cmd.op    = eg_pkg::ALU_RED;
               op_a      = q_ff;
               q_in      = '1;
            end else if (stat.done) begin
               cmd.start = 1'b1;
               cmd.op    = eg_pkg::ALU_MUL;
               op_a      = res_r;
               op_b      = s1_ff;
               st_in     = S_QS_W;
            end else if (!stat.busy && q_ff == '1) begin
               // q itself all ones: still reduce it
               cmd.start = 1'b1;
               cmd.op    = eg_pkg::ALU_RED;
               op_a      = q_ff;
               q_in      = '0;
            end
         end
         S_QS_W: if (stat.done) begin
            sub_v = (s0_ff >= res_r) ? s0_ff - res_r : s0_ff + (modulus - res_r);
            s0_in = s1_ff;
            s1_in = sub_v;
            st_in = S_IV;
         end
         S_RM: begin
            cmd.start = 1'b1;
            cmd.op    = eg_pkg::ALU_RED;
            op_a      = x_ff;
            st_in     = S_RM_W;
         end
         S_RM_W: if (stat.done) begin
            cmd.start = 1'b1;
            cmd.op    = eg_pkg::ALU_MUL;
            op_a      = res_r;
            op_b      = acc_ff;
            st_in     = S_FMUL_W;
         end
         S_FMUL_W: if (stat.done) begin
            if (func_ff == eg_pkg::FUNC_ENCRYPT) second_in = res_r;
            else first_in = res_r;
            st_in = S_OUT;
         end
         S_OUT: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
      func_ff   <= func_in;
      pass_ff   <= pass_in;
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      acc_ff    <= acc_in;
      x_ff      <= x_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      s0_ff     <= s0_in;
      s1_ff     <= s1_in;
      q_ff      <= q_in;
      k_ff      <= k_in;
   end

   assign idle       = (st_ff == S_IDLE);
   assign finish     = (st_ff == S_OUT);
   assign res_first  = first_ff;
   assign res_second = second_ff;

   a_seq_out_from_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_IDLE && !start) |=> st_ff == S_IDLE)
      else $error("sequencer left idle without start");
   a_seq_dec_second_zero: assert property (@(posedge clock) disable iff (reset)
      (finish && func_ff == eg_pkg::FUNC_DECRYPT) |-> second_ff == '0)
      else $error("decrypt second word not zero");
   a_seq_out_one_cycle: assert property (@(posedge clock) disable iff (reset)
      finish |=> st_ff == S_IDLE)
      else $error("finish held");
endmodule

### rtl/elgamal_encrypt_decrypt_core.sv
// ElGamal encrypt/decrypt core.
// Input words arrive on req_valid/req_ready with req_func selecting encrypt
// (message, nonce) or decrypt (cipher_first, cipher_second). Each word yields
// one result word on rsp_valid/rsp_ready: out_first/out_second.
// The core takes one word at a time; req_ready is high only when idle and the
// output register is empty or being drained.
// Every modular product, reduction or division goes through one bit-serial
// unit. Each exponent bit costs a squaring plus a product when the bit is
// set. Encrypt runs two exponentiations and one product. Decrypt runs one
// exponentiation plus Euclid, each step a division, a reduction and a
// product, up to about 47 steps at 32 bits. Short exponents take fewer
// squarings; a zero modulus skips the arithmetic and answers zeros.
// The csr_ port writes modulus, generator, public_key, private_key by index;
// write only while idle.
// Reset clears the sequencer and the output valid flag and loads modulus 467,
// generator 2, public key 1, private key 1. A stalled rsp holds its word and
// blocks the next request until taken.
module elgamal_encrypt_decrypt_core #(
   parameter int WORD_BITS = eg_pkg::WORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [WORD_BITS-1:0]              req_message,
   input  logic [WORD_BITS-1:0]              req_nonce,
   input  logic [WORD_BITS-1:0]              req_cipher_first,
   input  logic [WORD_BITS-1:0]              req_cipher_second,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [WORD_BITS-1:0]              rsp_out_first,
   output logic [WORD_BITS-1:0]              rsp_out_second,
   input  logic                              csr_write,
   input  logic [eg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]              csr_data
);
   logic [WORD_BITS-1:0] mod_ff, gen_ff, pub_ff, prv_ff;
   logic                 vld_ff, vld_in, idle, finish, start;
   logic [WORD_BITS-1:0] f_ff, s_ff, res_first, res_second;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= WORD_BITS'(467);
         gen_ff <= WORD_BITS'(2);
         pub_ff <= WORD_BITS'(1);
         prv_ff <= WORD_BITS'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            eg_pkg::CSR_MODULUS:     mod_ff <= csr_data;
            eg_pkg::CSR_GENERATOR:   gen_ff <= csr_data;
            eg_pkg::CSR_PUBLIC_KEY:  pub_ff <= csr_data;
            eg_pkg::CSR_PRIVATE_KEY: prv_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_ready = idle && (!vld_ff || rsp_ready);
   assign start     = req_valid && req_ready;

   eg_seq #(.WORD_BITS(WORD_BITS)) u_seq (
      .clock(clock), .reset(reset), .start(start), .func(req_func),
      .message(req_message), .nonce(req_nonce), .cipher_first(req_cipher_first),
      .cipher_second(req_cipher_second), .modulus(mod_ff), .generator(gen_ff),
      .public_key(pub_ff), .private_key(prv_ff), .idle(idle), .finish(finish),
      .res_first(res_first), .res_second(res_second)
   );

   always_comb begin
      vld_in = vld_ff;
      if (rsp_ready) vld_in = 1'b0;
      if (finish) vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= vld_in;
      if (finish) begin
         f_ff <= res_first;
         s_ff <= res_second;
      end
   end

   assign rsp_valid      = vld_ff;
   assign rsp_out_first  = f_ff;
   assign rsp_out_second = s_ff;

   a_top_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish |-> (!vld_ff || rsp_ready))
      else $error("result word overwritten");
   a_top_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_out_first))
      else $error("stalled word changed");
   a_top_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_ready)
      else $error("ready while working");
endmodule

### tb/elgamal_encrypt_decrypt_core_test.sv
`timescale 1ns / 1ps

module elgamal_encrypt_decrypt_core_test;

   localparam int W = 32;
   localparam int IDLE_LIMIT = 60000;
   localparam int RANDOM_WORDS = 111;

   typedef longint unsigned u64_type;

   typedef struct {
      int          cfg;
      logic        func;
      logic [W-1:0] msg;
      logic [W-1:0] nonce;
      logic [W-1:0] c1;
      logic [W-1:0] c2;
      bit          known;
      logic [W-1:0] e1;
      logic [W-1:0] e2;
   } vector_type;

   typedef struct {
      logic [W-1:0] first;
      logic [W-1:0] second;
   } cipher_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready, req_func = 0;
   logic [W-1:0] req_message = 0, req_nonce = 0, req_cipher_first = 0, req_cipher_second = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [W-1:0] rsp_out_first, rsp_out_second;
   logic csr_write = 0;
   logic [eg_pkg::CSR_INDEX_BITS-1:0] csr_index = eg_pkg::CSR_MODULUS;
   logic [W-1:0] csr_data = 0;

   u64_type p_reg = 467, g_reg = 2, y_reg = 1, x_reg = 1;
   cipher_type pending_q[$];
   int errors = 0;
   int idle_count = 0;
   bit no_gaps = 0;

   elgamal_encrypt_decrypt_core i_dut (.*);

   initial forever #1 clock = ~clock;

   function automatic u64_type mul_mod(u64_type a, u64_type b, u64_type m);
      return ((a % m) * (b % m)) % m;
   endfunction

   function automatic u64_type pow_mod(u64_type base, u64_type e, u64_type m);
      u64_type acc;
      acc = 1 % m;
      base = base % m;
      while (e != 0) begin
         if (e[0]) acc = mul_mod(acc, base, m);
         base = mul_mod(base, base, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic u64_type inv_mod(u64_type a, u64_type m);
      u64_type r0, r1, s0, s1, q, rn, sn, t;
      r0 = a % m;
      r1 = m;
      s0 = 1 % m;
      s1 = 0;
      while (r1 != 0) begin
         q = r0 / r1;
         rn = r0 - q * r1;
         t = mul_mod(q % m, s1, m);
         sn = (s0 >= t) ? s0 - t : s0 + (m - t);
         r0 = r1;
         r1 = rn;
         s0 = s1;
         s1 = sn;
      end
      return s0;
   endfunction

   function automatic cipher_type elgamal_result(logic func, u64_type msg, u64_type k,
                                                 u64_type c1, u64_type c2);
      cipher_type r;
      r.first = 0;
      r.second = 0;
      if (p_reg != 0) begin
         if (func == eg_pkg::FUNC_ENCRYPT) begin
            r.first = W'(pow_mod(g_reg, k, p_reg));
            r.second = W'(mul_mod(msg, pow_mod(y_reg, k, p_reg), p_reg));
         end else begin
            r.first = W'(mul_mod(c2, inv_mod(pow_mod(c1, x_reg, p_reg), p_reg), p_reg));
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cipher_type exp_word;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write)
            idle_count <= 0;
         else
            idle_count <= idle_count + 1;
         if (idle_count >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
         if (req_valid && req_ready)
            pending_q.push_back(elgamal_result(req_func, u64_type'(req_message),
                                               u64_type'(req_nonce),
                                               u64_type'(req_cipher_first),
                                               u64_type'(req_cipher_second)));
         if (rsp_valid && rsp_ready) begin
            if (pending_q.size() == 0) begin
               $error("unexpected word: out_first %h out_second %h",
                      rsp_out_first, rsp_out_second);
               errors++;
            end else begin
               exp_word = pending_q.pop_front();
               if (rsp_out_first !== exp_word.first) begin
                  $error("out_first: expected %h, actual %h", exp_word.first, rsp_out_first);
                  errors++;
               end
               if (rsp_out_second !== exp_word.second) begin
                  $error("out_second: expected %h, actual %h",
                         exp_word.second, rsp_out_second);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic csr_set(u64_type p, u64_type g, u64_type y, u64_type x);
      logic [W-1:0] vals[4];
      vals = '{W'(p), W'(g), W'(y), W'(x)};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1;
         csr_index <= i[eg_pkg::CSR_INDEX_BITS-1:0];
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_write <= 0;
      p_reg = p;
      g_reg = g;
      y_reg = y;
      x_reg = x;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send(logic func, logic [W-1:0] msg, logic [W-1:0] k,
                       logic [W-1:0] c1, logic [W-1:0] c2);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= func;
      req_message <= msg;
      req_nonce <= k;
      req_cipher_first <= c1;
      req_cipher_second <= c2;
      do @(posedge clock); while (!req_ready);
   endtask

   u64_type cfg_tab[5][4] = '{
      '{467, 2, 1, 1},
      '{0, 5, 7, 9},
      '{1, 5, 7, 9},
      '{64'hFFFFFFFB, 64'hFFFFFFFF, 64'hFFFFFFFF, 64'hFFFFFFFF},
      '{15, 4, 7, 3}
   };

   vector_type directed[19] = '{
      '{0, eg_pkg::FUNC_ENCRYPT, 5, 0, 0, 0, 1, 1, 5},
      '{0, eg_pkg::FUNC_ENCRYPT, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0},
      '{0, eg_pkg::FUNC_ENCRYPT, 100, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0},
      '{0, eg_pkg::FUNC_DECRYPT, 0, 0, 0, 5, 1, 0, 0},
      '{0, eg_pkg::FUNC_DECRYPT, 0, 0, 1, 7, 1, 7, 0},
      '{0, eg_pkg::FUNC_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        0, 0, 0},
      '{0, eg_pkg::FUNC_DECRYPT, 0, 0, 467, 9, 1, 0, 0},
      '{1, eg_pkg::FUNC_ENCRYPT, 9, 3, 0, 0, 1, 0, 0},
      '{1, eg_pkg::FUNC_DECRYPT, 0, 0, 4, 9, 1, 0, 0},
      '{2, eg_pkg::FUNC_ENCRYPT, 9, 0, 0, 0, 1, 0, 0},
      '{2, eg_pkg::FUNC_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 1, 0, 0},
      '{2, eg_pkg::FUNC_DECRYPT, 0, 0, 3, 8, 1, 0, 0},
      '{3, eg_pkg::FUNC_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0, 0},
      '{3, eg_pkg::FUNC_ENCRYPT, 0, 1, 0, 0, 0, 0, 0},
      '{3, eg_pkg::FUNC_DECRYPT, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0},
      '{3, eg_pkg::FUNC_DECRYPT, 0, 0, 0, 32'h12345678, 1, 0, 0},
      '{4, eg_pkg::FUNC_DECRYPT, 0, 0, 3, 7, 0, 0, 0},
      '{4, eg_pkg::FUNC_DECRYPT, 0, 0, 2, 11, 0, 0, 0},
      '{4, eg_pkg::FUNC_ENCRYPT, 20, 5, 0, 0, 0, 0, 0}
   };

   initial begin
      int cur_cfg;
      u64_type p, g, x;
      logic [W-1:0] k, m;
      cipher_type ct, model;
      bit have_ct;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      cur_cfg = 0;
      foreach (directed[i]) begin
         if (directed[i].cfg != cur_cfg) begin
            drain();
            cur_cfg = directed[i].cfg;
            csr_set(cfg_tab[cur_cfg][0], cfg_tab[cur_cfg][1],
                    cfg_tab[cur_cfg][2], cfg_tab[cur_cfg][3]);
         end
         if (directed[i].known) begin
            model = elgamal_result(directed[i].func, u64_type'(directed[i].msg),
                                   u64_type'(directed[i].nonce), u64_type'(directed[i].c1),
                                   u64_type'(directed[i].c2));
            if (model.first !== directed[i].e1) begin
               $error("table row %0d: out_first expected %h, model %h", i,
                      directed[i].e1, model.first);
               errors++;
            end
            if (model.second !== directed[i].e2) begin
               $error("table row %0d: out_second expected %h, model %h", i,
                      directed[i].e2, model.second);
               errors++;
            end
         end
         send(directed[i].func, directed[i].msg, directed[i].nonce,
              directed[i].c1, directed[i].c2);
      end

      have_ct = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 16 == 0) begin
            req_valid <= 0;
            drain();
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 6))
               0: p = 467;
               1: p = 65521;
               2: p = 64'hFFFFFFFB;
               3: p = 15;
               4: p = $urandom_range(0, 1);
               default: p = $urandom;
            endcase
            g = $urandom;
            x = $urandom;
            csr_set(p, g, (p == 0) ? u64_type'($urandom) : pow_mod(g, x, p), x);
            have_ct = 0;
         end
         m = $urandom;
         k = $urandom;
         if ($urandom_range(0, 3) == 0)
            k = k >> $urandom_range(0, 31);
         case ($urandom_range(0, 9)) inside
            [0:3]: begin
               send(eg_pkg::FUNC_ENCRYPT, m, k, $urandom, $urandom);
               if (p_reg != 0) begin
                  ct = elgamal_result(eg_pkg::FUNC_ENCRYPT, u64_type'(m), u64_type'(k), 0, 0);
                  have_ct = 1;
               end
            end
            [4:7]:
               if (have_ct)
                  send(eg_pkg::FUNC_DECRYPT, $urandom, $urandom, ct.first, ct.second);
               else
                  send(eg_pkg::FUNC_DECRYPT, $urandom, $urandom, $urandom, $urandom);
            default:
               send(1'($urandom_range(0, 1)), m, k, $urandom, $urandom);
         endcase
      end
      req_valid <= 0;
      drain();
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
